>>> rtl/ckvf_pkg.sv
// Shared types and constants for the coalescing key/value queue.
// Used by ckvf_cell and coalescing_key_value_fifo_core; depends on nothing.
package ckvf_pkg;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [2:0] OUTCOME_APPENDED = 3'd0;
    localparam logic [2:0] OUTCOME_UPDATED  = 3'd1;
    localparam logic [2:0] OUTCOME_DROPPED  = 3'd2;
    localparam logic [2:0] OUTCOME_POPPED   = 3'd3;
    localparam logic [2:0] OUTCOME_EMPTY    = 3'd4;

    typedef struct packed {
        logic push;
        logic pop;
        logic any_hit;
    } t_cell_ctrl;

endpackage

>>> rtl/ckvf_cell.sv
// One slot of the queue: a key, a value and a valid flag.
// Compares its key against a push, shifts from its neighbor on a pop; uses ckvf_pkg.
module ckvf_cell
    import ckvf_pkg::*;
#(
    parameter int KEY_WIDTH   = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctrl             i_ctrl,
    input  logic [KEY_WIDTH-1:0]   i_key,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_prev_valid,
    input  logic [KEY_WIDTH-1:0]   i_next_key,
    input  logic [VALUE_WIDTH-1:0] i_next_value,
    input  logic                   i_next_valid,
    output logic [KEY_WIDTH-1:0]   o_key,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic                   o_valid,
    output logic                   o_hit
);

    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_value;
    logic                   r_valid;
    logic [KEY_WIDTH-1:0]   n_key;
    logic [VALUE_WIDTH-1:0] n_value;
    logic                   n_valid;
    logic                   hit;

    assign hit = r_valid && (r_key == i_key);

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        n_valid = r_valid;
        priority if (i_ctrl.pop) begin
            n_key   = i_next_key;
            n_value = i_next_value;
            n_valid = i_next_valid;
        end else if (i_ctrl.push && hit) begin
            n_value = i_value;
        end else if (i_ctrl.push && !i_ctrl.any_hit && !r_valid && i_prev_valid) begin
            n_key   = i_key;
            n_value = i_value;
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_hit   = hit;

endmodule

>>> rtl/coalescing_key_value_fifo_core.sv
// Top level of the coalescing key/value queue: a chain of ckvf_cell slots,
// the occupancy counter and the result register; uses ckvf_pkg.
//
// Channel  Dir  tdata (low bit up)                 tuser
// s_axis   in   key, value                         command
// m_axis   out  out_key, out_value, occupancy      outcome
//
// For every item all cells compare the key in parallel, and
// the pop shift moves every slot one place in the same cycle.
// One result per item lands in an output register; a new item is taken
// whenever that register is empty or being emptied in the same cycle.
// Reset clears the cell valid flags, the counter and the output valid flag.
module coalescing_key_value_fifo_core
    import ckvf_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // Fields from bit 0: key, value, zero padding.
    input  logic [((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // Fields from bit 0: command.
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // Fields from bit 0: out_key, out_value, occupancy, zero padding.
    output logic [((KEY_WIDTH + VALUE_WIDTH + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                m_axis_tdata,
    // Fields from bit 0: outcome.
    output logic [2:0]          m_axis_tuser
);

    localparam int CW     = $clog2(DEPTH + 1);
    localparam int OUT_DW = ((KEY_WIDTH + VALUE_WIDTH + CW + 7) / 8) * 8;

    logic [KEY_WIDTH-1:0]   cell_key   [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]       cell_valid;
    logic [DEPTH-1:0]       cell_hit;

    logic [KEY_WIDTH-1:0]   in_key;
    logic [VALUE_WIDTH-1:0] in_value;
    logic                   accept;
    logic                   any_hit;
    logic                   full;
    logic                   empty;
    t_cell_ctrl             ctrl;

    logic                   r_out_valid;
    logic [2:0]             r_outcome;
    logic [KEY_WIDTH-1:0]   r_out_key;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic [CW-1:0]          r_out_occ;
    logic [CW-1:0]          r_count;
    logic [2:0]             n_outcome;
    logic [KEY_WIDTH-1:0]   n_out_key;
    logic [VALUE_WIDTH-1:0] n_out_value;
    logic [CW-1:0]          n_count;

    assign in_key   = s_axis_tdata[KEY_WIDTH-1:0];
    assign in_value = s_axis_tdata[KEY_WIDTH +: VALUE_WIDTH];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign any_hit = |cell_hit;
    assign full    = cell_valid[DEPTH-1];
    assign empty   = !cell_valid[0];

    assign ctrl.push    = accept && (s_axis_tuser == CMD_PUSH);
    assign ctrl.pop     = accept && (s_axis_tuser == CMD_POP) && !empty;
    assign ctrl.any_hit = any_hit;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                   prev_valid;
        logic [KEY_WIDTH-1:0]   next_key;
        logic [VALUE_WIDTH-1:0] next_value;
        logic                   next_valid;

        if (i == 0) begin : g_head
            assign prev_valid = 1'b1;
        end else begin : g_body
            assign prev_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign next_key   = '0;
            assign next_value = '0;
            assign next_valid = 1'b0;
        end else begin : g_link
            assign next_key   = cell_key[i+1];
            assign next_value = cell_value[i+1];
            assign next_valid = cell_valid[i+1];
        end

        ckvf_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_key        (in_key),
            .i_value      (in_value),
            .i_prev_valid (prev_valid),
            .i_next_key   (next_key),
            .i_next_value (next_value),
            .i_next_valid (next_valid),
            .o_key        (cell_key[i]),
            .o_value      (cell_value[i]),
            .o_valid      (cell_valid[i]),
            .o_hit        (cell_hit[i])
        );
    end

    always_comb begin
        n_out_key   = '0;
        n_out_value = '0;
        n_count     = r_count;
        if (s_axis_tuser == CMD_PUSH) begin
            priority if (any_hit) begin
                n_outcome = OUTCOME_UPDATED;
            end else if (full) begin
                n_outcome = OUTCOME_DROPPED;
            end else begin
                n_outcome = OUTCOME_APPENDED;
                n_count   = r_count + CW'(1);
            end
        end else begin
            if (empty) begin
                n_outcome = OUTCOME_EMPTY;
            end else begin
                n_outcome   = OUTCOME_POPPED;
                n_out_key   = cell_key[0];
                n_out_value = cell_value[0];
                n_count     = r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_outcome   <= n_outcome;
            r_out_key   <= n_out_key;
            r_out_value <= n_out_value;
            r_out_occ   <= n_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_outcome;
    assign m_axis_tdata  = OUT_DW'({r_out_occ, r_out_value, r_out_key});

endmodule
